// File: sv/bdpc_pkg.sv
// shared types and constants for the button debounce and press classifier
package bdpc_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 3'd4;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 16'd8;
    localparam logic [CFG_W-1:0] RST_SHORT_MIN = 16'd20;
    localparam logic [CFG_W-1:0] RST_SHORT_MAX = 16'd84;
    localparam logic [CFG_W-1:0] RST_LONG_MIN  = 16'd250;
    localparam logic [CFG_W-1:0] RST_LONG_MAX  = 16'd850;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_SHORT = 2'd1,
        CLASS_LONG  = 2'd2
    } t_class;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] short_min_ticks;
        logic [CFG_W-1:0] short_max_ticks;
        logic [CFG_W-1:0] long_min_ticks;
        logic [CFG_W-1:0] long_max_ticks;
    } t_cfg;

    typedef struct packed {
        logic   pressed_level;
        logic   indicator_level;
        t_class press_class;
        logic   class_changed;
    } t_result;

endpackage

// File: sv/bdpc_cfg.sv
// configuration register bank
module bdpc_cfg
    import bdpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE:  n_cfg.debounce_ticks  = i_cfg_data;
                REG_SHORT_MIN: n_cfg.short_min_ticks = i_cfg_data;
                REG_SHORT_MAX: n_cfg.short_max_ticks = i_cfg_data;
                REG_LONG_MIN:  n_cfg.long_min_ticks  = i_cfg_data;
                REG_LONG_MAX:  n_cfg.long_max_ticks  = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= RST_DEBOUNCE;
            r_cfg.short_min_ticks <= RST_SHORT_MIN;
            r_cfg.short_max_ticks <= RST_SHORT_MAX;
            r_cfg.long_min_ticks  <= RST_LONG_MIN;
            r_cfg.long_max_ticks  <= RST_LONG_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/bdpc_core.sv
// debounce counter, debounced level and press class state with one-sample update
module bdpc_core
    import bdpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_raw_level,
    input  logic    i_tick,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_prev_raw;
    logic                   r_deb;
    logic [COUNT_WIDTH-1:0] r_elapsed;
    t_class                 r_class;
    logic                   r_ind;

    logic                   n_prev_raw;
    logic                   n_deb;
    logic [COUNT_WIDTH-1:0] n_elapsed;
    t_class                 n_class;
    logic                   n_ind;

    logic [CMP_W-1:0] elapsed_x;
    logic             in_short;
    logic             in_long;

    always_comb begin
        n_prev_raw = i_raw_level;
        if (i_raw_level != r_prev_raw) begin
            n_elapsed = '0;
        end else if (i_tick && (r_elapsed != CNT_MAX)) begin
            n_elapsed = r_elapsed + 1'b1;
        end else begin
            n_elapsed = r_elapsed;
        end
    end

    assign elapsed_x = CMP_W'(n_elapsed);
    // inverted windows never match since both bounds must hold
    assign in_short = (elapsed_x >= CMP_W'(i_cfg.short_min_ticks))
                   && (elapsed_x <= CMP_W'(i_cfg.short_max_ticks));
    assign in_long  = (elapsed_x >= CMP_W'(i_cfg.long_min_ticks))
                   && (elapsed_x <= CMP_W'(i_cfg.long_max_ticks));

    always_comb begin
        n_deb   = r_deb;
        n_class = r_class;
        n_ind   = r_ind;
        if ((elapsed_x > CMP_W'(i_cfg.debounce_ticks)) && (i_raw_level != r_deb)) begin
            n_deb = i_raw_level;
            if (!i_raw_level) begin
                n_class = CLASS_NONE;
            end
        end
        // short window is tested first and wins on overlap unless the class is already short
        if (n_deb) begin
            if (in_short && (n_class != CLASS_SHORT)) begin
                n_ind   = 1'b1;
                n_class = CLASS_SHORT;
            end else if (in_long && (n_class != CLASS_LONG)) begin
                n_ind   = 1'b0;
                n_class = CLASS_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= 1'b0;
            r_deb      <= 1'b0;
            r_elapsed  <= '0;
            r_class    <= CLASS_NONE;
            r_ind      <= 1'b0;
        end else if (i_accept) begin
            r_prev_raw <= n_prev_raw;
            r_deb      <= n_deb;
            r_elapsed  <= n_elapsed;
            r_class    <= n_class;
            r_ind      <= n_ind;
        end
    end

    assign o_result.pressed_level   = n_deb;
    assign o_result.indicator_level = n_ind;
    assign o_result.press_class     = n_class;
    assign o_result.class_changed   = (n_class != r_class);

`ifndef NO_ASSERTIONS
    a_edge_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_raw_level != r_prev_raw) |=> r_elapsed == '0)
        else $error("raw level change did not clear the tick count");

    a_class_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_deb |-> r_class == CLASS_NONE)
        else $error("press class set while debounced level is released");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_elapsed) && $stable(r_class) && $stable(r_deb))
        else $error("state changed without an input transfer");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_elapsed == CNT_MAX) && (i_raw_level == r_prev_raw)
        |=> r_elapsed == CNT_MAX)
        else $error("tick count wrapped at its limit");
`endif

endmodule

// File: sv/bdpc_out.sv
// result register between the update logic and the output channel
module bdpc_out
    import bdpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: sv/button_debounce_press_classifier.sv
// top level of the push-button debounce and short/long press classifier
//
// Input channel: i_valid / o_stall carry one poll of the button per transfer:
// i_raw_level (1 = pressed) and i_tick (one millisecond tick since the last poll).
// Output channel: o_valid / i_stall carry one result per input transfer:
// o_pressed_level, o_indicator_level, o_press_class, o_class_changed.
// The result of a poll is registered and valid in the cycle after the poll is accepted.
// Throughput is one poll per cycle while o_stall is low; the state update is a single
// counter step and a handful of at least 16-bit compares feeding the result register.
// o_stall is high only while a result waits in the result register and the
// receiver stalls; the held result does not change until it is taken.
// Configuration: i_cfg_we writes i_cfg_data to the register chosen by
// i_cfg_index (0 debounce, 1 short min, 2 short max, 3 long min, 4 long max);
// other indexes are ignored. Write only while the block is idle.
// Synchronous reset clears the debounce state, press class and indicator,
// empties the result register and restores the register defaults
// (8, 20, 84, 250, 850 ticks).
module button_debounce_press_classifier
    import bdpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_raw_level,
    input  logic                 i_tick,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_pressed_level,
    output logic                 o_indicator_level,
    output logic [1:0]           o_press_class,
    output logic                 o_class_changed
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    out_valid;
    logic    accept;

    // a new poll may enter whenever the result register can hand over or is empty
    assign o_stall = out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    bdpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bdpc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_raw_level (i_raw_level),
        .i_tick      (i_tick),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    bdpc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_valid           = out_valid;
    assign o_pressed_level   = out_result.pressed_level;
    assign o_indicator_level = out_result.indicator_level;
    assign o_press_class     = out_result.press_class;
    assign o_class_changed   = out_result.class_changed;

endmodule
